/* hw/rtl/osq_pkg.sv */
// Shared types and constants for the oldest-or-richest service queue.
package osq_pkg;

   localparam int Capacity   = 1024;
   localparam int AmountBits = 20;
   localparam int SlotBits   = $clog2(Capacity);
   localparam int NumBits    = 32;
   localparam int QueueDepth = 2;
   localparam int QueueBits  = $clog2(QueueDepth);

   localparam logic [NumBits-1:0] NumLast = {NumBits{1'b1}};

   typedef enum logic [1:0] {
      OP_ARRIVE  = 2'd0,
      OP_OLDEST  = 2'd1,
      OP_RICHEST = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_SERVED  = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_DROPPED = 2'd2,
      ST_UNUSED  = 2'd3
   } status_type;

   // Command passed from the front end to the back end
   typedef struct packed {
      op_type                op;
      logic [AmountBits-1:0] amount;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SKIP_RD,
      S_SKIP,
      S_SCAN,
      S_RESULT
   } state_type;

   function automatic logic [SlotBits-1:0] slot_of(input logic [NumBits-1:0] n);
      logic [NumBits-1:0] m;
      m = n - NumBits'(1);
      return m[SlotBits-1:0];
   endfunction

endpackage

/* hw/rtl/osq_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module osq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/osq_front.sv */
// Front end: accepts request beats, drops unused opcodes, queues commands.
module osq_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic [osq_pkg::AmountBits-1:0] req_amount,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output osq_pkg::cmd_type   cmd
);

   osq_pkg::cmd_type q_ff [osq_pkg::QueueDepth];
   logic [osq_pkg::QueueBits-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [osq_pkg::QueueBits:0]   count_ff, count_in;
   logic push, pop, keep;
   osq_pkg::cmd_type new_cmd;

   assign req_ready = (count_ff != (osq_pkg::QueueBits+1)'(osq_pkg::QueueDepth));
   assign keep      = (osq_pkg::op_type'(req_op) != osq_pkg::OP_NONE);
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op     = osq_pkg::op_type'(req_op);
      new_cmd.amount = req_amount;
   end

   // Queue pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (osq_pkg::QueueBits+1)'(push) - (osq_pkg::QueueBits+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

/* hw/rtl/osq_back.sv */
// Back end: table of waiting clients, oldest skip and richest scan.
module osq_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   output logic                         cmd_ready,
   input  osq_pkg::cmd_type             cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [osq_pkg::NumBits-1:0]  rsp_served_number,
   output logic [1:0]                   rsp_status
);

   localparam int SB = osq_pkg::SlotBits;
   localparam int NB = osq_pkg::NumBits;
   localparam int AB = osq_pkg::AmountBits;

   osq_pkg::state_type state_ff, state_in;
   osq_pkg::op_type    op_ff, op_in;
   logic [NB-1:0] oldest_ff, oldest_in, next_ff, next_in;
   logic [NB-1:0] scan_ff, scan_in, best_ff, best_in;
   logic [AB-1:0] best_amt_ff, best_amt_in;
   logic          found_ff, found_in;
   logic [NB-1:0] out_num_ff, out_num_in;
   logic [1:0]    out_st_ff, out_st_in;
   logic          out_v_ff, out_v_in;

   // Table entry: {waiting flag, amount}
   logic          ram_we;
   logic [SB-1:0] ram_wa, ram_ra;
   logic [AB:0]   ram_wd, ram_rd;
   logic          rd_waits;
   logic [AB-1:0] rd_amount;
   logic          accept, full, at_end, out_free, emit;
   logic [NB-1:0] emit_num;
   logic [1:0]    emit_st;
   logic [NB-1:0] oldest_next, scan_next;

   osq_ram #(.Width(AB+1), .Depth(osq_pkg::Capacity)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign out_free    = !out_v_ff || rsp_ready;
   assign cmd_ready   = (state_ff == osq_pkg::S_IDLE);
   assign accept      = cmd_valid && cmd_ready;
   assign full        = ((next_ff - oldest_ff) >= NB'(osq_pkg::Capacity)) ||
                        (next_ff == osq_pkg::NumLast);
   assign at_end      = (oldest_ff == next_ff);
   assign oldest_next = oldest_ff + NB'(1);
   assign scan_next   = scan_ff + NB'(1);
   assign rd_waits    = ram_rd[AB];
   assign rd_amount   = ram_rd[AB-1:0];

   // Read address runs one slot ahead of the slot being examined
   always_comb begin
      case (state_ff)
         osq_pkg::S_SKIP: ram_ra = osq_pkg::slot_of(oldest_next);
         osq_pkg::S_SCAN: ram_ra = osq_pkg::slot_of(scan_next);
         default:         ram_ra = osq_pkg::slot_of(oldest_ff);
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         osq_pkg::S_IDLE: begin
            if (accept && cmd.op != osq_pkg::OP_ARRIVE) begin
               state_in = osq_pkg::S_SKIP_RD;
            end else if (accept && full) begin
               state_in = osq_pkg::S_RESULT;
            end
         end
         osq_pkg::S_SKIP_RD: state_in = osq_pkg::S_SKIP;
         osq_pkg::S_SKIP: begin
            if (at_end) begin
               state_in = (op_ff == osq_pkg::OP_NONE) ? osq_pkg::S_IDLE : osq_pkg::S_RESULT;
            end else if (rd_waits) begin
               if (op_ff == osq_pkg::OP_NONE) begin
                  state_in = osq_pkg::S_IDLE;
               end else if (op_ff == osq_pkg::OP_RICHEST && oldest_next != next_ff) begin
                  state_in = osq_pkg::S_SCAN;
               end else begin
                  state_in = osq_pkg::S_RESULT;
               end
            end
         end
         osq_pkg::S_SCAN: begin
            if (scan_next == next_ff) begin
               state_in = osq_pkg::S_RESULT;
            end
         end
         osq_pkg::S_RESULT: begin
            if (out_free) begin
               if (op_ff != osq_pkg::OP_ARRIVE && found_ff) begin
                  state_in = osq_pkg::S_SKIP_RD;
               end else begin
                  state_in = osq_pkg::S_IDLE;
               end
            end
         end
         default: state_in = osq_pkg::S_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      op_in       = op_ff;
      oldest_in   = oldest_ff;
      next_in     = next_ff;
      scan_in     = scan_ff;
      best_in     = best_ff;
      best_amt_in = best_amt_ff;
      found_in    = found_ff;
      ram_we      = 1'b0;
      ram_wa      = osq_pkg::slot_of(next_ff);
      ram_wd      = {1'b1, cmd.amount};
      emit        = 1'b0;
      emit_num    = '0;
      emit_st     = osq_pkg::ST_SERVED;
      case (state_ff)
         osq_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = cmd.op;
               found_in = 1'b0;
               if (cmd.op == osq_pkg::OP_ARRIVE && !full) begin
                  ram_we  = 1'b1;
                  next_in = next_ff + NB'(1);
               end
            end
         end
         osq_pkg::S_SKIP: begin
            if (!at_end && !rd_waits) begin
               oldest_in = oldest_next;
            end else if (!at_end && op_ff != osq_pkg::OP_NONE) begin
               // Head waits: it is the first candidate for either rule
               found_in    = 1'b1;
               best_in     = oldest_ff;
               best_amt_in = rd_amount;
               scan_in     = oldest_next;
            end
         end
         osq_pkg::S_SCAN: begin
            // Strictly larger wins, so ties keep the earliest
            if (rd_waits && rd_amount > best_amt_ff) begin
               best_in     = scan_ff;
               best_amt_in = rd_amount;
            end
            scan_in = scan_next;
         end
         osq_pkg::S_RESULT: begin
            if (out_free) begin
               emit = 1'b1;
               if (op_ff == osq_pkg::OP_ARRIVE) begin
                  emit_st = osq_pkg::ST_DROPPED;
               end else if (found_ff) begin
                  emit_num = best_ff;
                  ram_we   = 1'b1;
                  ram_wa   = osq_pkg::slot_of(best_ff);
                  ram_wd   = '0;
               end else begin
                  emit_st = osq_pkg::ST_EMPTY;
               end
               // Trailing skip runs with no op and ends in IDLE
               op_in = osq_pkg::OP_NONE;
            end
         end
         default: ;
      endcase
   end

   // Output register
   always_comb begin
      out_v_in   = out_v_ff && !rsp_ready;
      out_num_in = out_num_ff;
      out_st_in  = out_st_ff;
      if (emit) begin
         out_v_in   = 1'b1;
         out_num_in = emit_num;
         out_st_in  = emit_st;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_served_number = out_num_ff;
   assign rsp_status        = out_st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= osq_pkg::S_IDLE;
         op_ff     <= osq_pkg::OP_NONE;
         oldest_ff <= NB'(1);
         next_ff   <= NB'(1);
         found_ff  <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         oldest_ff <= oldest_in;
         next_ff   <= next_in;
         found_ff  <= found_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      best_ff     <= best_in;
      best_amt_ff <= best_amt_in;
      out_num_ff  <= out_num_in;
      out_st_ff   <= out_st_in;
   end

endmodule

/* hw/rtl/oldest_or_richest_service_queue.sv */
// Top level of the oldest-or-richest service queue.
// Usage:
//   req channel: op (0 arrive, 1 serve oldest, 2 serve richest) and amount.
//   rsp channel: served_number and status (0 served, 1 empty, 2 dropped).
//   An accepted arrival gives no beat; every serve gives one beat, as does a
//   dropped arrival into a full table. Op 3 is discarded by the front end.
// Flow:
//   The front end holds a two-entry command queue, so req beats are taken
//   while the back end works. A command passes through that queue and is
//   picked up when the back end is idle. An arrival is handled in the idle
//   state; a dropped arrival goes through the result state. A serve passes
//   through a skip read, a skip pass over removed slots at the head, a scan
//   over the later slots of the live window for serve-richest only, and the
//   result state; rsp_valid comes from the output register. After a removal
//   the back end runs another skip pass to move the head past removed slots.
// Reset:
//   Synchronous, active high. The table empties and numbering restarts at 1.
// Stall:
//   A finished beat sits in the output register; the back end keeps working
//   on the skip pass while it waits, and stalls only on the next result.
module oldest_or_richest_service_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_op,
   input  logic [osq_pkg::AmountBits-1:0]  req_amount,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [osq_pkg::NumBits-1:0]     rsp_served_number,
   output logic [1:0]                      rsp_status
);

   logic             cmd_valid, cmd_ready;
   osq_pkg::cmd_type cmd;

   osq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_amount (req_amount),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   osq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_served_number (rsp_served_number),
      .rsp_status        (rsp_status)
   );

   // A served beat carries a nonzero number, other statuses carry zero
   a_num_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == osq_pkg::ST_SERVED) == (rsp_served_number != '0)))
      else $error("served number disagrees with status");

   // Status code never the unused one
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != osq_pkg::ST_UNUSED))
      else $error("unused status code");

   // A stalled rsp beat stays valid and keeps its number
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_served_number))
      else $error("rsp beat changed while stalled");

endmodule

/* test/oldest_or_richest_service_queue_tb.sv */
// Testbench for the oldest-or-richest service queue: random and directed beats against a predictor.
module oldest_or_richest_service_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [osq_pkg::NumBits-1:0] num;
      osq_pkg::status_type         status;
   } served_type;

   // Predicts served clients and holds the results still owed by the block
   class service_board;
      logic [osq_pkg::AmountBits-1:0] amounts [osq_pkg::Capacity];
      bit                             waiting [osq_pkg::Capacity];
      logic [osq_pkg::NumBits-1:0]    oldest;
      logic [osq_pkg::NumBits-1:0]    next_num;
      served_type                     owed [$];
      int                             errors;
      int                             matched;
      int                             served_cnt;
      int                             empty_cnt;
      int                             dropped_cnt;

      function new();
         foreach (waiting[i]) waiting[i] = 0;
         oldest   = 1;
         next_num = 1;
         errors   = 0;
         matched  = 0;
         served_cnt = 0;
         empty_cnt  = 0;
         dropped_cnt = 0;
      endfunction

      function logic [osq_pkg::SlotBits-1:0] slot(logic [osq_pkg::NumBits-1:0] n);
         logic [osq_pkg::NumBits-1:0] m;
         m = n - 1;
         return m[osq_pkg::SlotBits-1:0];
      endfunction

      function void advance_head();
         while (oldest != next_num && !waiting[slot(oldest)]) oldest++;
      endfunction

      function void push(logic [osq_pkg::NumBits-1:0] n, osq_pkg::status_type st);
         served_type r;
         r.num    = n;
         r.status = st;
         owed.insert(owed.size(), r);
      endfunction

      // Note an accepted request beat
      function void note_request(osq_pkg::op_type op, logic [osq_pkg::AmountBits-1:0] amt);
         logic [osq_pkg::NumBits-1:0] n, best;
         logic [osq_pkg::AmountBits-1:0] best_amt;
         bit found;
         case (op)
            osq_pkg::OP_ARRIVE: begin
               if (next_num - oldest >= osq_pkg::Capacity || next_num == osq_pkg::NumLast) begin
                  push(0, osq_pkg::ST_DROPPED);
               end else begin
                  amounts[slot(next_num)] = amt;
                  waiting[slot(next_num)] = 1;
                  next_num++;
               end
            end
            osq_pkg::OP_OLDEST: begin
               advance_head();
               if (oldest == next_num) begin
                  push(0, osq_pkg::ST_EMPTY);
               end else begin
                  n = oldest;
                  waiting[slot(n)] = 0;
                  advance_head();
                  push(n, osq_pkg::ST_SERVED);
               end
            end
            osq_pkg::OP_RICHEST: begin
               advance_head();
               if (oldest == next_num) begin
                  push(0, osq_pkg::ST_EMPTY);
               end else begin
                  found    = 0;
                  best     = 0;
                  best_amt = 0;
                  for (n = oldest; n != next_num; n++) begin
                     if (waiting[slot(n)] && (!found || amounts[slot(n)] > best_amt)) begin
                        found    = 1;
                        best     = n;
                        best_amt = amounts[slot(n)];
                     end
                  end
                  waiting[slot(best)] = 0;
                  advance_head();
                  push(best, osq_pkg::ST_SERVED);
               end
            end
            default: ;
         endcase
      endfunction

      function void fail_note(string what);
         errors++;
         if (errors <= 10) $display("mismatch: %s", what);
      endfunction

      // Check one response beat against the oldest owed result
      function void check_response(logic [osq_pkg::NumBits-1:0] num, logic [1:0] st);
         served_type e;
         if (owed.size() == 0) begin
            fail_note($sformatf("unexpected beat num=%0d status=%0d", num, st));
            return;
         end
         e = owed.pop_front();
         if (num !== e.num || st !== e.status)
            fail_note($sformatf("expected num=%0d status=%0d, got num=%0d status=%0d",
                                e.num, e.status, num, st));
         else
            matched++;
         case (e.status)
            osq_pkg::ST_SERVED:  served_cnt++;
            osq_pkg::ST_EMPTY:   empty_cnt++;
            default:             dropped_cnt++;
         endcase
      endfunction
   endclass

   localparam int StallLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_op = osq_pkg::OP_NONE;
   logic [19:0] req_amount = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_served_number;
   logic [1:0]  rsp_status;

   service_board board = new();
   bit quiet = 0;
   int idle_cycles = 0;
   int beats_in = 0;

   oldest_or_richest_service_queue dut (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_amount,
      .rsp_valid, .rsp_ready, .rsp_served_number, .rsp_status
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver backpressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 0;
      else rsp_ready <= quiet || ($urandom_range(99) >= 9);
   end

   // Response check and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_response(rsp_served_number, rsp_status);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("watchdog: no beat for %0d cycles", StallLimit);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Drive one request beat; valid stays high into the next call unless idling
   task automatic send(osq_pkg::op_type op, logic [osq_pkg::AmountBits-1:0] amt);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 9) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid  <= 1;
      req_op     <= op;
      req_amount <= amt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(op, amt);
      beats_in++;
   endtask

   task automatic hold_off();
      @(negedge clock);
      req_valid <= 0;
      wait (board.owed.size() == 0);
      repeat (2200) @(posedge clock);
   endtask

   function automatic logic [19:0] pick_amount();
      if ($urandom_range(3) == 0) return 20'($urandom_range(7));
      return 20'($urandom);
   endfunction

   function automatic osq_pkg::op_type pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 50) return osq_pkg::OP_ARRIVE;
      if (r < 72) return osq_pkg::OP_OLDEST;
      if (r < 95) return osq_pkg::OP_RICHEST;
      return osq_pkg::OP_NONE;
   endfunction

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty serves, unused op, amount extremes and ties
      send(osq_pkg::OP_RICHEST, 0);
      send(osq_pkg::OP_OLDEST, 0);
      send(osq_pkg::OP_NONE, 20'hFFFFF);
      send(osq_pkg::OP_ARRIVE, 0);
      send(osq_pkg::OP_ARRIVE, 20'hFFFFF);
      send(osq_pkg::OP_ARRIVE, 20'hFFFFF);
      send(osq_pkg::OP_ARRIVE, 5);
      send(osq_pkg::OP_RICHEST, 0);
      send(osq_pkg::OP_RICHEST, 0);
      send(osq_pkg::OP_ARRIVE, 20'h55555);
      send(osq_pkg::OP_ARRIVE, 20'hAAAAA);
      send(osq_pkg::OP_OLDEST, 0);
      send(osq_pkg::OP_RICHEST, 0);
      send(osq_pkg::OP_OLDEST, 0);
      send(osq_pkg::OP_OLDEST, 0);
      send(osq_pkg::OP_OLDEST, 0);
      send(osq_pkg::OP_RICHEST, 0);
      hold_off();

      // Random mix with a stretch free of idling and one pause
      for (int i = 0; i < 563; i++) begin
         quiet = (i >= 200 && i < 320);
         if (i == 400) hold_off();
         send(pick_op(), pick_amount());
      end
      quiet = 0;
      @(negedge clock);
      req_valid <= 0;

      wait (board.owed.size() == 0);
      repeat (2200) @(posedge clock);
      if (board.owed.size() != 0) board.fail_note("results left over");

      $display("%0d request beats, %0d results checked: %0d served, %0d empty, %0d dropped",
               beats_in, board.matched, board.served_cnt, board.empty_cnt, board.dropped_cnt);
      $display("mismatches: %0d", board.errors);
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
